/* hw/rtl/sm83_pkg.sv */
// Shared definitions for the SM83 ALU and shift unit: operation codes,
// flag bit positions and the result bundle. No dependencies.
package sm83_pkg;

  localparam int KIND_W = 5;

  localparam logic [KIND_W-1:0] OP_ADD  = 5'd0;
  localparam logic [KIND_W-1:0] OP_ADC  = 5'd1;
  localparam logic [KIND_W-1:0] OP_SUB  = 5'd2;
  localparam logic [KIND_W-1:0] OP_SBC  = 5'd3;
  localparam logic [KIND_W-1:0] OP_AND  = 5'd4;
  localparam logic [KIND_W-1:0] OP_XOR  = 5'd5;
  localparam logic [KIND_W-1:0] OP_OR   = 5'd6;
  localparam logic [KIND_W-1:0] OP_CP   = 5'd7;
  localparam logic [KIND_W-1:0] OP_DAA  = 5'd8;
  localparam logic [KIND_W-1:0] OP_CPL  = 5'd9;
  localparam logic [KIND_W-1:0] OP_RLCA = 5'd10;
  localparam logic [KIND_W-1:0] OP_RLA  = 5'd11;
  localparam logic [KIND_W-1:0] OP_RRCA = 5'd12;
  localparam logic [KIND_W-1:0] OP_RRA  = 5'd13;
  localparam logic [KIND_W-1:0] OP_RLC  = 5'd14;
  localparam logic [KIND_W-1:0] OP_RL   = 5'd15;
  localparam logic [KIND_W-1:0] OP_RRC  = 5'd16;
  localparam logic [KIND_W-1:0] OP_RR   = 5'd17;
  localparam logic [KIND_W-1:0] OP_SLA  = 5'd18;
  localparam logic [KIND_W-1:0] OP_SRA  = 5'd19;
  localparam logic [KIND_W-1:0] OP_SWAP = 5'd20;

  // Flag bit positions within the 4-bit flag nibble.
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  localparam logic [7:0] DAA_LO  = 8'h06;
  localparam logic [7:0] DAA_HI  = 8'h60;
  localparam logic [7:0] BCD_MAX = 8'h99;

  typedef struct packed {
    logic [7:0] result;
    logic [3:0] flags;
    logic       writes;
  } alu_res_t;

endpackage

/* hw/rtl/sm83_alu_core.sv */
// Combinational SM83 arithmetic, logic, rotate and shift datapath.
// Depends on sm83_pkg for operation codes, flag positions and alu_res_t.
module sm83_alu_core (
  input  logic [sm83_pkg::KIND_W-1:0] kind,
  input  logic [7:0]                  acc,
  input  logic [7:0]                  operand,
  input  logic [3:0]                  flags_in,
  output sm83_pkg::alu_res_t          res
);
  import sm83_pkg::*;

  logic       cin;
  logic       use_c;
  logic [8:0] sum;
  logic [4:0] sum_lo;
  logic [8:0] diff;
  logic [4:0] diff_lo;
  logic       daa_hi;
  logic       daa_c;
  logic [7:0] daa_t;
  logic [7:0] daa_r;
  logic [7:0] r;
  logic [3:0] f;
  logic       wr;

  assign cin   = flags_in[FLAG_C];
  assign use_c = ((kind == OP_ADC) || (kind == OP_SBC)) && cin;

  assign sum     = {1'b0, acc} + {1'b0, operand} + {8'd0, use_c};
  assign sum_lo  = {1'b0, acc[3:0]} + {1'b0, operand[3:0]} + {4'd0, use_c};
  assign diff    = {1'b0, acc} - {1'b0, operand} - {8'd0, use_c};
  assign diff_lo = {1'b0, acc[3:0]} - {1'b0, operand[3:0]} - {4'd0, use_c};

  // Decimal adjust. The high correction never changes the low nibble, so the
  // low test can look at the accumulator directly.
  always_comb begin
    daa_hi = cin || (acc > BCD_MAX);
    daa_c  = cin;
    daa_t  = acc;
    if (!flags_in[FLAG_N]) begin
      if (daa_hi) begin
        daa_t = acc + DAA_HI;
        daa_c = 1'b1;
      end
      if (flags_in[FLAG_H] || (acc[3:0] > 4'd9)) begin
        daa_r = daa_t + DAA_LO;
      end else begin
        daa_r = daa_t;
      end
    end else begin
      if (cin) begin
        daa_t = acc - DAA_HI;
      end
      if (flags_in[FLAG_H]) begin
        daa_r = daa_t - DAA_LO;
      end else begin
        daa_r = daa_t;
      end
    end
  end

  always_comb begin
    r  = acc;
    f  = flags_in;
    wr = 1'b1;
    case (kind)
      OP_ADD, OP_ADC: begin
        r = sum[7:0];
        f = {r == 8'd0, 1'b0, sum_lo[4], sum[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        r  = diff[7:0];
        f  = {r == 8'd0, 1'b1, diff_lo[4], diff[8]};
        wr = (kind != OP_CP);
      end
      OP_AND: begin
        r = acc & operand;
        f = {r == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        r = acc ^ operand;
        f = {r == 8'd0, 3'b000};
      end
      OP_OR: begin
        r = acc | operand;
        f = {r == 8'd0, 3'b000};
      end
      OP_DAA: begin
        r = daa_r;
        f = {r == 8'd0, flags_in[FLAG_N], 1'b0, daa_c};
      end
      OP_CPL: begin
        r = ~acc;
        f = {flags_in[FLAG_Z], 1'b1, 1'b1, flags_in[FLAG_C]};
      end
      OP_RLCA: begin
        r = {acc[6:0], acc[7]};
        f = {3'b000, acc[7]};
      end
      OP_RLA: begin
        r = {acc[6:0], cin};
        f = {3'b000, acc[7]};
      end
      OP_RRCA: begin
        r = {acc[0], acc[7:1]};
        f = {3'b000, acc[0]};
      end
      OP_RRA: begin
        r = {cin, acc[7:1]};
        f = {3'b000, acc[0]};
      end
      OP_RLC: begin
        r = {operand[6:0], operand[7]};
        f = {r == 8'd0, 2'b00, operand[7]};
      end
      OP_RL: begin
        r = {operand[6:0], cin};
        f = {r == 8'd0, 2'b00, operand[7]};
      end
      OP_RRC: begin
        r = {operand[0], operand[7:1]};
        f = {r == 8'd0, 2'b00, operand[0]};
      end
      OP_RR: begin
        r = {cin, operand[7:1]};
        f = {r == 8'd0, 2'b00, operand[0]};
      end
      OP_SLA: begin
        r = {operand[6:0], 1'b0};
        f = {r == 8'd0, 2'b00, operand[7]};
      end
      OP_SRA: begin
        r = {operand[7], operand[7:1]};
        f = {r == 8'd0, 2'b00, operand[0]};
      end
      OP_SWAP: begin
        r = {operand[3:0], operand[7:4]};
        f = {r == 8'd0, 3'b000};
      end
      default: begin
        // Undefined codes pass the accumulator and flags through unwritten.
        r  = acc;
        f  = flags_in;
        wr = 1'b0;
      end
    endcase
  end

  assign res.result = r;
  assign res.flags  = f;
  assign res.writes = wr;

endmodule

/* hw/rtl/sm83_alu_and_shift_unit.sv */
// Top level of the SM83 ALU and shift unit: input register, datapath and
// result register. Depends on sm83_pkg and sm83_alu_core.
//
// Usage: an operation beat (kind, acc, operand, flags_in) is taken at a rising
// edge where in_valid is high and in_stall is low. It is held in an input
// register, passes through the combinational ALU, and lands in the result
// register, where result, flags_out and writes_result appear with out_valid.
// Throughput is one beat per cycle while out_stall is low; both registers
// advance together, and the depth of one ALU pass between them sets the
// cycle time. When the receiver raises out_stall the result register holds
// its beat, the input register fills behind it, and in_stall rises only
// when both are full. Up to two beats are in flight. There is no state
// between beats. A synchronous reset on rst empties both registers;
// payload is not cleared.
module sm83_alu_and_shift_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sm83_pkg::KIND_W-1:0] kind,
  input  logic [7:0]                  acc,
  input  logic [7:0]                  operand,
  input  logic [3:0]                  flags_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  result,
  output logic [3:0]                  flags_out,
  output logic                        writes_result
);
  import sm83_pkg::*;

  logic              s1_valid;
  logic [KIND_W-1:0] s1_kind;
  logic [7:0]        s1_acc;
  logic [7:0]        s1_operand;
  logic [3:0]        s1_flags;
  logic              s2_free;
  logic              s1_load;
  alu_res_t          core_res;

  assign s2_free  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s2_free;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s2_free || !s1_valid) begin
      s1_valid <= in_valid;
    end
    if (s1_load) begin
      s1_kind    <= kind;
      s1_acc     <= acc;
      s1_operand <= operand;
      s1_flags   <= flags_in;
    end
  end

  sm83_alu_core u_core (
    .kind     (s1_kind),
    .acc      (s1_acc),
    .operand  (s1_operand),
    .flags_in (s1_flags),
    .res      (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_free) begin
      out_valid <= s1_valid;
    end
    if (s2_free && s1_valid) begin
      result        <= core_res.result;
      flags_out     <= core_res.flags;
      writes_result <= core_res.writes;
    end
  end

  a_stall_needs_full : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("in_stall raised while a register is empty");

  a_accept_fills_s1 : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s1_valid)
    else $error("accepted beat did not reach the input register");

  a_advance_fills_out : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_free) |=> out_valid)
    else $error("beat lost between input and result registers");

  a_result_matches : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_free) |=> (result == $past(core_res.result) &&
                              flags_out == $past(core_res.flags)))
    else $error("result register does not hold the datapath output");

endmodule

/* tb/tb_sm83_alu_and_shift_unit.sv */
// Self-checking testbench for the SM83 ALU and shift unit: directed corner cases,
// then random operations under varied valid/stall pacing. Depends on sm83_pkg and the block.
`timescale 1ns / 1ps

module tb_sm83_alu_and_shift_unit;
  import sm83_pkg::*;

  localparam logic [KIND_W-1:0] OP_UNUSED_LAST = 5'd31;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [KIND_W-1:0] kind;
  logic [7:0]        acc;
  logic [7:0]        operand;
  logic [3:0]        flags_in;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        result;
  logic [3:0]        flags_out;
  logic              writes_result;

  alu_res_t pending_alu_results[$];
  int       error_count = 0;
  int       elapsed_clocks = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  sm83_alu_and_shift_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .acc           (acc),
    .operand       (operand),
    .flags_in      (flags_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result        (result),
    .flags_out     (flags_out),
    .writes_result (writes_result)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Expected byte, flags and write-back for one operation.
  function automatic alu_res_t sm83_compute(logic [KIND_W-1:0] op, logic [7:0] a,
                                            logic [7:0] b, logic [3:0] f);
    alu_res_t   res;
    logic       cin;
    logic       cy;
    logic [8:0] wide;
    logic [4:0] nib;
    logic [7:0] r;
    logic [3:0] fo;
    logic       wr;

    cin = f[FLAG_C];
    r   = a;
    fo  = '0;
    wr  = 1'b1;
    case (op)
      OP_ADD, OP_ADC: begin
        cy   = (op == OP_ADC) ? cin : 1'b0;
        wide = {1'b0, a} + {1'b0, b} + {8'd0, cy};
        nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cy};
        r    = wide[7:0];
        fo[FLAG_H] = nib[4];
        fo[FLAG_C] = wide[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        cy   = (op == OP_SBC) ? cin : 1'b0;
        // The sign bit of the nine-bit difference is the borrow.
        wide = {1'b0, a} - {1'b0, b} - {8'd0, cy};
        nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cy};
        r    = wide[7:0];
        fo[FLAG_N] = 1'b1;
        fo[FLAG_H] = nib[4];
        fo[FLAG_C] = wide[8];
        if (op == OP_CP) wr = 1'b0;
      end
      OP_AND: begin
        r = a & b;
        fo[FLAG_H] = 1'b1;
      end
      OP_XOR: r = a ^ b;
      OP_OR:  r = a | b;
      OP_DAA: begin
        cy = cin;
        if (!f[FLAG_N]) begin
          if (cy || a > BCD_MAX) begin
            r  = r + DAA_HI;
            cy = 1'b1;
          end
          if (f[FLAG_H] || r[3:0] > 4'd9) r = r + DAA_LO;
        end else begin
          if (cy) r = r - DAA_HI;
          if (f[FLAG_H]) r = r - DAA_LO;
        end
        fo[FLAG_N] = f[FLAG_N];
        fo[FLAG_C] = cy;
      end
      OP_CPL: begin
        r = ~a;
        fo = f;
        fo[FLAG_N] = 1'b1;
        fo[FLAG_H] = 1'b1;
      end
      OP_RLCA: begin r = {a[6:0], a[7]}; fo[FLAG_C] = a[7]; end
      OP_RLA:  begin r = {a[6:0], cin};  fo[FLAG_C] = a[7]; end
      OP_RRCA: begin r = {a[0], a[7:1]}; fo[FLAG_C] = a[0]; end
      OP_RRA:  begin r = {cin, a[7:1]};  fo[FLAG_C] = a[0]; end
      OP_RLC:  begin r = {b[6:0], b[7]}; fo[FLAG_C] = b[7]; end
      OP_RL:   begin r = {b[6:0], cin};  fo[FLAG_C] = b[7]; end
      OP_RRC:  begin r = {b[0], b[7:1]}; fo[FLAG_C] = b[0]; end
      OP_RR:   begin r = {cin, b[7:1]};  fo[FLAG_C] = b[0]; end
      OP_SLA:  begin r = {b[6:0], 1'b0}; fo[FLAG_C] = b[7]; end
      OP_SRA:  begin r = {b[7], b[7:1]}; fo[FLAG_C] = b[0]; end
      OP_SWAP: r = {b[3:0], b[7:4]};
      default: begin
        fo = f;
        wr = 1'b0;
      end
    endcase
    // Every flag-producing operation sets Z from the byte, except the accumulator
    // rotates, which always clear it, and CPL and the unused codes, which keep it.
    if (op <= OP_DAA || (op >= OP_RLC && op <= OP_SWAP)) fo[FLAG_Z] = (r == 8'h00);
    res.result = r;
    res.flags  = fo;
    res.writes = wr;
    return res;
  endfunction

  // Record the expectation for every beat the block takes.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      pending_alu_results.push_back(sm83_compute(kind, acc, operand, flags_in));
  end

  always @(posedge clk) begin : check_results
    alu_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_alu_results.size() == 0) begin
        $error("result beat with nothing expected: result=%h flags_out=%h writes_result=%b",
               result, flags_out, writes_result);
        error_count++;
      end else begin
        want = pending_alu_results.pop_front();
        if (result !== want.result) begin
          $error("result: expected %h, got %h", want.result, result);
          error_count++;
        end
        if (flags_out !== want.flags) begin
          $error("flags_out: expected %b, got %b", want.flags, flags_out);
          error_count++;
        end
        if (writes_result !== want.writes) begin
          $error("writes_result: expected %b, got %b", want.writes, writes_result);
          error_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    elapsed_clocks++;
    if (elapsed_clocks == CYCLE_LIMIT) begin
      $display("[sm83_alu_and_shift_unit] ERROR");
      $finish;
    end
  end

  // Called just after a falling edge; returns just after the falling edge that
  // follows acceptance, with in_valid still high.
  task automatic send_op(logic [KIND_W-1:0] op, logic [7:0] a, logic [7:0] b,
                         logic [3:0] f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    kind     = op;
    acc      = a;
    operand  = b;
    flags_in = f;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly uniform bytes, with a share of values at nibble and BCD boundaries.
  function automatic logic [7:0] pick_byte();
    logic [7:0] corners[8];
    corners = '{8'h00, 8'h0f, 8'h10, 8'h7f, 8'h80, 8'h99, 8'h9a, 8'hff};
    if ($urandom_range(7) == 0) return corners[$urandom_range(7)];
    return 8'($urandom_range(255));
  endfunction

  task automatic test_arith_extremes();
    send_op(OP_ADD, 8'hff, 8'h01, 4'h0);
    send_op(OP_ADC, 8'h0f, 8'h00, 4'h1);
    send_op(OP_SUB, 8'h00, 8'h01, 4'h0);
    send_op(OP_SBC, 8'h10, 8'h0f, 4'h1);
    send_op(OP_CP,  8'h42, 8'h42, 4'h0);
  endtask

  task automatic test_logic_and_cpl();
    send_op(OP_AND, 8'hff, 8'h00, 4'hf);
    send_op(OP_XOR, 8'h5a, 8'h5a, 4'h0);
    send_op(OP_OR,  8'h00, 8'h80, 4'hf);
    // CPL keeps Z and C.
    send_op(OP_CPL, 8'h00, 8'h00, 4'h9);
  endtask

  task automatic test_daa_adjust();
    send_op(OP_DAA, 8'h9a, 8'h00, 4'h0);
    send_op(OP_DAA, 8'h00, 8'h00, 4'h2);
    send_op(OP_DAA, 8'h00, 8'h00, 4'h7);
    send_op(OP_DAA, 8'h45, 8'h00, 4'h4);
  endtask

  task automatic test_accumulator_rotates();
    // A zero byte must still leave Z clear here.
    send_op(OP_RLCA, 8'h80, 8'h00, 4'h8);
    send_op(OP_RLA,  8'h80, 8'h00, 4'h0);
    send_op(OP_RRCA, 8'h01, 8'h00, 4'h0);
    send_op(OP_RRA,  8'h01, 8'h00, 4'h1);
  endtask

  task automatic test_prefix_shifts();
    send_op(OP_RLC,  8'h00, 8'h00, 4'hf);
    send_op(OP_RL,   8'h00, 8'h80, 4'h0);
    send_op(OP_RRC,  8'h00, 8'h01, 4'h0);
    send_op(OP_RR,   8'h00, 8'h00, 4'h1);
    send_op(OP_SLA,  8'h00, 8'h80, 4'h0);
    send_op(OP_SRA,  8'h00, 8'h81, 4'h0);
    send_op(OP_SWAP, 8'h00, 8'hf0, 4'h0);
  endtask

  task automatic test_unused_code();
    send_op(OP_UNUSED_LAST, 8'hff, 8'h00, 4'hf);
  endtask

  task automatic test_random_ops(int count, int idle_pct, int stall_pct);
    logic [KIND_W-1:0] op;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      if ($urandom_range(9) == 0) op = KIND_W'($urandom_range(OP_UNUSED_LAST, OP_SWAP + 1));
      else op = KIND_W'($urandom_range(OP_SWAP, OP_ADD));
      send_op(op, pick_byte(), pick_byte(), 4'($urandom_range(15)));
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    kind      = OP_ADD;
    acc       = 8'h00;
    operand   = 8'h00;
    flags_in  = 4'h0;
    out_stall = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct  = 20;
    recv_stall_pct = 83;
    test_arith_extremes();
    test_logic_and_cpl();
    test_daa_adjust();
    test_accumulator_rotates();
    test_prefix_shifts();
    test_unused_code();

    test_random_ops(642, 20, 83);
    test_random_ops(642, 83, 20);
    test_random_ops(641, 0, 0);
    in_valid = 1'b0;

    while (pending_alu_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[sm83_alu_and_shift_unit] OK");
    end else begin
      $display("[sm83_alu_and_shift_unit] ERROR");
    end
    $finish;
  end

endmodule
